@@ rtl/core/jpp_pkg.sv @@
// ============================================================================
// jpp_pkg: shared types, constants and microcode for the JSON pretty printer
// Holds the character codes, the classifier result, and the control store.
// ============================================================================
package jpp_pkg;

    localparam int unsigned IND_W  = 10;
    localparam int unsigned STEP_W = 5;
    localparam int unsigned SP_W   = 5;

    localparam logic [SP_W-1:0]   MAX_SPACES = 5'd30;
    localparam logic [IND_W-1:0]  INDENT_MAX = 10'h3FF;
    localparam logic [STEP_W-1:0] STEP_RESET = 5'd2;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // microcode addresses
    typedef enum logic [3:0] {
        U_IDLE,
        U_DISP,
        U_EMIT_C,
        U_LEAD_NL,
        U_LEAD_SP,
        U_STRUCT_C,
        U_TRAIL_NL,
        U_TRAIL_SP,
        U_FINAL,
        U_ERR
    } t_upc;

    typedef enum logic [2:0] {
        E_NONE,
        E_CHAR,
        E_STRUCT,
        E_NL,
        E_SPACE,
        E_ERR,
        E_FINAL
    } t_emit;

    typedef enum logic [2:0] {
        J_WAIT,
        J_GOTO,
        J_DISPATCH,
        J_SPZERO,
        J_LOOP,
        J_TRAIL
    } t_jmp;

    typedef struct packed {
        t_emit emit;
        t_jmp  jmp;
        t_upc  tgt_a;
        t_upc  tgt_b;
    } t_uword;

    typedef struct packed {
        logic is_quote;
        logic is_blank;
        logic is_open;
        logic is_close;
        logic is_comma;
        logic trail_ok;
    } t_cls;

    // Control store. tgt_a is taken when the jump condition holds.
    function automatic t_uword uc_rom(input t_upc a);
        t_uword w;
        case (a)
            U_IDLE:     w = '{E_NONE,   J_WAIT,     U_DISP,     U_IDLE};
            U_DISP:     w = '{E_NONE,   J_DISPATCH, U_IDLE,     U_IDLE};
            U_EMIT_C:   w = '{E_CHAR,   J_GOTO,     U_FINAL,    U_FINAL};
            U_LEAD_NL:  w = '{E_NL,     J_SPZERO,   U_STRUCT_C, U_LEAD_SP};
            U_LEAD_SP:  w = '{E_SPACE,  J_LOOP,     U_STRUCT_C, U_LEAD_SP};
            U_STRUCT_C: w = '{E_STRUCT, J_TRAIL,    U_TRAIL_NL, U_FINAL};
            U_TRAIL_NL: w = '{E_NL,     J_SPZERO,   U_FINAL,    U_TRAIL_SP};
            U_TRAIL_SP: w = '{E_SPACE,  J_LOOP,     U_FINAL,    U_TRAIL_SP};
            U_FINAL:    w = '{E_FINAL,  J_GOTO,     U_IDLE,     U_IDLE};
            U_ERR:      w = '{E_ERR,    J_GOTO,     U_FINAL,    U_FINAL};
            default:    w = '{E_NONE,   J_GOTO,     U_IDLE,     U_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/jpp_classify.sv @@
// ============================================================================
// jpp_classify: character classifier
// Sorts the current byte into JSON classes and evaluates the lookahead rule
// that decides whether a trailing newline follows a structural byte.
// ============================================================================
module jpp_classify (
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_la,
    output jpp_pkg::t_cls   o_cls
);

    logic la_closes;
    logic la_opens;

    always_comb begin
        la_closes = (i_la == jpp_pkg::CH_RBRACK) || (i_la == jpp_pkg::CH_RBRACE) ||
                    (i_la == jpp_pkg::CH_COMMA);
        la_opens  = (i_la == jpp_pkg::CH_LBRACK) || (i_la == jpp_pkg::CH_LBRACE);

        o_cls.is_quote = (i_byte == jpp_pkg::CH_QUOTE);
        o_cls.is_blank = (i_byte == jpp_pkg::CH_SPACE) ||
                         ((i_byte >= jpp_pkg::CH_TAB) && (i_byte <= jpp_pkg::CH_CR));
        o_cls.is_open  = (i_byte == jpp_pkg::CH_LBRACK) || (i_byte == jpp_pkg::CH_LBRACE);
        o_cls.is_close = (i_byte == jpp_pkg::CH_RBRACK) || (i_byte == jpp_pkg::CH_RBRACE);
        o_cls.is_comma = (i_byte == jpp_pkg::CH_COMMA);
        // no newline before a close or comma, nor between a comma and an open
        o_cls.trail_ok = !la_closes && !(o_cls.is_comma && la_opens);
    end

endmodule

@@ rtl/core/json_pretty_print_stream_core.sv @@
// ============================================================================
// json_pretty_print_stream_core: streaming JSON pretty printer
// Microcoded sequencer: a control store steps a small datapath per byte.
// ============================================================================
// Path: the input word is registered, dispatched in U_DISP, and its first
//   result word is registered in the output register. Each extra result word
//   (newlines, indent spaces) takes its own microcode step, each held while the
//   output is stalled. The single output register paces the sequencer.
// Reset: synchronous, active low; clears indent, string and error state and
//   sets indent_step to 2. No clearing pass.
module json_pretty_print_stream_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic [7:0] i_lookahead_byte,
    input  logic       i_end_of_text,
    // result words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_syntax_error,
    output logic       o_run_last
);

    jpp_pkg::t_upc   r_upc, n_upc;
    jpp_pkg::t_uword uw;
    jpp_pkg::t_cls   cls;
    jpp_pkg::t_upc   raw_nxt, nxt, d_tgt;

    logic [7:0]                   r_c;
    logic [7:0]                   r_la;
    logic                         r_last;
    logic [jpp_pkg::IND_W-1:0]    r_indent, n_indent;
    logic                         r_instr, n_instr;
    logic                         r_err_l, n_err_l;
    logic [jpp_pkg::STEP_W-1:0]   r_step;
    logic [jpp_pkg::SP_W-1:0]     r_sp, n_sp;

    logic                         r_ov;
    logic [7:0]                   r_ob;
    logic                         r_oerr;
    logic                         r_olast;

    logic [jpp_pkg::SP_W-1:0]     spc;
    logic [jpp_pkg::IND_W:0]      inc_sum;
    logic                         under;
    logic                         slot_free;
    logic                         adv;
    logic                         in_acc;
    logic                         emit_now;
    logic [7:0]                   e_byte;
    logic                         e_err;

    jpp_classify u_cls (
        .i_byte (r_c),
        .i_la   (r_la),
        .o_cls  (cls)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ov;
    assign o_out_byte     = r_ob;
    assign o_syntax_error = r_oerr;
    assign o_run_last     = r_olast;

    always_comb begin
        uw        = jpp_pkg::uc_rom(r_upc);
        slot_free = !r_ov || i_out_ready;
        adv       = (r_upc != jpp_pkg::U_IDLE) && slot_free;

        spc = (r_indent < {{(jpp_pkg::IND_W - jpp_pkg::SP_W){1'b0}}, jpp_pkg::MAX_SPACES})
            ? r_indent[jpp_pkg::SP_W-1:0] : jpp_pkg::MAX_SPACES;
        under   = r_indent < {{(jpp_pkg::IND_W - jpp_pkg::STEP_W){1'b0}}, r_step};
        inc_sum = {1'b0, r_indent} + {{(jpp_pkg::IND_W + 1 - jpp_pkg::STEP_W){1'b0}}, r_step};

        // dispatch on the byte class
        if (r_err_l) begin
            d_tgt = jpp_pkg::U_FINAL;
        end else if (r_instr || cls.is_quote) begin
            d_tgt = jpp_pkg::U_EMIT_C;
        end else if (cls.is_blank) begin
            d_tgt = jpp_pkg::U_FINAL;
        end else if (cls.is_close) begin
            d_tgt = under ? jpp_pkg::U_ERR : jpp_pkg::U_LEAD_NL;
        end else if (cls.is_open) begin
            d_tgt = jpp_pkg::U_LEAD_NL;
        end else if (cls.is_comma) begin
            d_tgt = jpp_pkg::U_STRUCT_C;
        end else begin
            d_tgt = jpp_pkg::U_EMIT_C;
        end

        case (uw.jmp)
            jpp_pkg::J_WAIT:     raw_nxt = i_in_valid ? uw.tgt_a : uw.tgt_b;
            jpp_pkg::J_GOTO:     raw_nxt = uw.tgt_a;
            jpp_pkg::J_DISPATCH: raw_nxt = d_tgt;
            jpp_pkg::J_SPZERO:   raw_nxt = (spc == '0) ? uw.tgt_a : uw.tgt_b;
            jpp_pkg::J_LOOP:     raw_nxt = (r_sp == {{(jpp_pkg::SP_W-1){1'b0}}, 1'b1})
                                           ? uw.tgt_a : uw.tgt_b;
            jpp_pkg::J_TRAIL:    raw_nxt = cls.trail_ok ? uw.tgt_a : uw.tgt_b;
            default:             raw_nxt = jpp_pkg::U_IDLE;
        endcase
        // skip the final newline step unless this is the last word
        nxt = ((raw_nxt == jpp_pkg::U_FINAL) && !r_last) ? jpp_pkg::U_IDLE : raw_nxt;

        o_in_ready = (r_upc == jpp_pkg::U_IDLE) || (adv && (nxt == jpp_pkg::U_IDLE));
        in_acc     = i_in_valid && o_in_ready;

        if (r_upc == jpp_pkg::U_IDLE) begin
            n_upc = in_acc ? jpp_pkg::U_DISP : jpp_pkg::U_IDLE;
        end else if (adv) begin
            n_upc = in_acc ? jpp_pkg::U_DISP : nxt;
        end else begin
            n_upc = r_upc;
        end

        n_indent = r_indent;
        n_instr  = r_instr;
        n_err_l  = r_err_l;
        n_sp     = r_sp;
        if (adv) begin
            case (r_upc)
                jpp_pkg::U_DISP: begin
                    if (d_tgt == jpp_pkg::U_LEAD_NL && cls.is_close) begin
                        n_indent = r_indent - {{(jpp_pkg::IND_W - jpp_pkg::STEP_W){1'b0}},
                                               r_step};
                    end
                end
                jpp_pkg::U_EMIT_C: begin
                    if (cls.is_quote) begin
                        n_instr = !r_instr;
                    end
                end
                jpp_pkg::U_LEAD_NL, jpp_pkg::U_TRAIL_NL: begin
                    n_sp = spc;
                end
                jpp_pkg::U_LEAD_SP, jpp_pkg::U_TRAIL_SP: begin
                    n_sp = r_sp - {{(jpp_pkg::SP_W-1){1'b0}}, 1'b1};
                end
                jpp_pkg::U_STRUCT_C: begin
                    if (cls.is_open) begin
                        n_indent = inc_sum[jpp_pkg::IND_W] ? jpp_pkg::INDENT_MAX
                                                           : inc_sum[jpp_pkg::IND_W-1:0];
                    end
                end
                jpp_pkg::U_ERR: begin
                    n_err_l = 1'b1;
                end
                jpp_pkg::U_FINAL: begin
                    n_indent = '0;
                    n_instr  = 1'b0;
                    n_err_l  = 1'b0;
                end
                default: begin
                end
            endcase
        end

        e_err = 1'b0;
        case (uw.emit)
            jpp_pkg::E_CHAR, jpp_pkg::E_STRUCT: e_byte = r_c;
            jpp_pkg::E_NL, jpp_pkg::E_FINAL:    e_byte = jpp_pkg::CH_NL;
            jpp_pkg::E_SPACE:                   e_byte = jpp_pkg::CH_SPACE;
            jpp_pkg::E_ERR: begin
                e_byte = jpp_pkg::CH_NUL;
                e_err  = 1'b1;
            end
            default:                            e_byte = jpp_pkg::CH_NUL;
        endcase
        emit_now = adv && (uw.emit != jpp_pkg::E_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= jpp_pkg::U_IDLE;
            r_indent <= '0;
            r_instr  <= 1'b0;
            r_err_l  <= 1'b0;
            r_step   <= jpp_pkg::STEP_RESET;
            r_ov     <= 1'b0;
            r_sp     <= '0;
        end else begin
            r_upc    <= n_upc;
            r_indent <= n_indent;
            r_instr  <= n_instr;
            r_err_l  <= n_err_l;
            r_sp     <= n_sp;
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (slot_free) begin
                r_ov <= emit_now;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_c    <= i_text_byte;
            r_la   <= i_lookahead_byte;
            r_last <= i_end_of_text;
        end
        if (emit_now) begin
            r_ob    <= e_byte;
            r_oerr  <= e_err;
            r_olast <= (nxt == jpp_pkg::U_IDLE);
        end
    end

    // ------------------------------------------------------------------------
    a_err_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_syntax_error) |-> (o_out_byte == jpp_pkg::CH_NUL))
        else $error("error word carries data");

    a_sp_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == jpp_pkg::U_LEAD_SP || r_upc == jpp_pkg::U_TRAIL_SP) |-> (r_sp != '0))
        else $error("space loop entered with zero count");

    a_err_latch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_upc == jpp_pkg::U_ERR) |=> r_err_l)
        else $error("underflow did not latch the error");

    a_final_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_upc == jpp_pkg::U_FINAL) |=> (r_indent == '0 && !r_instr && !r_err_l))
        else $error("state not cleared after the last word");

endmodule
